// ----- design/kmd_pkg.sv -----
// shared types and constants for the key matrix debounce reporter
`default_nettype none

package kmd_pkg;

  localparam int ROWS = 5;
  localparam int COLS = 12;

  localparam int RAW_W = 60;
  localparam int NKEYS = (ROWS * COLS >= RAW_W) ? RAW_W : ROWS * COLS;
  localparam logic [RAW_W-1:0] KEY_MASK =
    (NKEYS == RAW_W) ? {RAW_W{1'b1}} : ((RAW_W'(1) << NKEYS) - RAW_W'(1));

  localparam int TIME_W   = 32;
  localparam int DBT_W    = 20;
  localparam logic [DBT_W-1:0] DBT_RESET = DBT_W'(5000);

  localparam int ROW_W = 3;
  localparam int COL_W = 4;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef enum logic [0:0] {
    KIND_EVENT  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_STATUS
  } back_state_e;

  // one scan worth of work for the back end
  typedef struct packed {
    logic [RAW_W-1:0] diff;
    logic [RAW_W-1:0] raw;
    logic             keep;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             pressed;
    logic             keep;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/kmd_front.sv -----
// front end: debounce timer, stable matrix and command classification
`default_nettype none

module kmd_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [kmd_pkg::DBT_W-1:0]   cfg_wdata_i,
  input  wire                         accept_i,
  input  wire  [kmd_pkg::RAW_W-1:0]   raw_keys_i,
  input  wire                         first_scan_i,
  input  wire  [kmd_pkg::TIME_W-1:0]  now_us_i,
  output kmd_pkg::cmd_t               cmd_o
);
  import kmd_pkg::*;

  logic [DBT_W-1:0]  dbt_q;
  logic [RAW_W-1:0]  stable_q, stable_d;
  logic [RAW_W-1:0]  last_raw_q;
  logic [TIME_W-1:0] start_q, start_d;
  logic              running_q, running_d;

  logic [RAW_W-1:0]  raw_m;
  logic [TIME_W-1:0] elapsed;
  logic              changed;
  logic              commit;
  logic [RAW_W-1:0]  diff;

  always_comb begin
    raw_m   = raw_keys_i & KEY_MASK;
    changed = (raw_m != last_raw_q) || first_scan_i;
    elapsed = now_us_i - start_q;
    commit  = !changed && running_q && (elapsed >= TIME_W'(dbt_q));
    diff    = commit ? (stable_q ^ raw_m) : '0;

    cmd_o.diff = diff;
    cmd_o.raw  = raw_m;
    // all keys released by this commit: cue to sleep
    cmd_o.keep = !(commit && (diff != '0) && (raw_m == '0));

    stable_d  = stable_q;
    start_d   = start_q;
    running_d = running_q;
    if (changed) begin
      start_d   = now_us_i;
      running_d = 1'b1;
    end else if (commit) begin
      stable_d  = raw_m;
      start_d   = '0;
      running_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbt_q <= DBT_RESET;
    end else if (cfg_we_i) begin
      dbt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= '0;
      last_raw_q <= '0;
      start_q    <= '0;
      running_q  <= 1'b0;
    end else if (accept_i) begin
      stable_q   <= stable_d;
      last_raw_q <= raw_m;
      start_q    <= start_d;
      running_q  <= running_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/kmd_cmd_fifo.sv -----
// short command queue between front and back end
`default_nettype none

module kmd_cmd_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            wr_i,
  input  kmd_pkg::cmd_t  wdata_i,
  output logic           full_o,
  input  wire            rd_i,
  output kmd_pkg::cmd_t  rdata_o,
  output logic           empty_o
);
  import kmd_pkg::*;

  cmd_t                mem_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CNT_W-1:0] cnt_q;
  logic                do_wr, do_rd;

  assign full_o  = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/kmd_back.sv -----
// back end: walks the diff a key per cycle unless stalled; emits words
`default_nettype none

module kmd_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  kmd_pkg::cmd_t  cmd_i,
  input  wire            cmd_empty_i,
  output logic           cmd_rd_o,
  input  wire            pop_i,
  output logic           out_valid_o,
  output kmd_pkg::res_t  res_o
);
  import kmd_pkg::*;

  back_state_e      state_q, state_d;
  logic [RAW_W-1:0] diff_q, raw_q;
  logic             keep_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             out_valid_q;
  res_t             res_q;

  logic out_free;
  logic load;
  logic advance;
  logic emit;
  res_t res_d;

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) state_d = BK_SCAN;
      end
      BK_SCAN: begin
        if (diff_q == '0) state_d = BK_STATUS;
      end
      BK_STATUS: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    advance = 1'b0;
    emit    = 1'b0;
    res_d   = '{kind: KIND_EVENT, row: row_q, col: col_q, pressed: raw_q[0],
                keep: 1'b0, last: 1'b0};
    unique case (state_q)
      BK_IDLE: begin
        load = !cmd_empty_i;
      end
      BK_SCAN: begin
        if (diff_q != '0) begin
          if (diff_q[0]) begin
            emit    = out_free;
            advance = out_free;
          end else begin
            advance = 1'b1;
          end
        end
      end
      BK_STATUS: begin
        emit  = out_free;
        res_d = '{kind: KIND_STATUS, row: '0, col: '0, pressed: 1'b0,
                  keep: keep_q, last: 1'b1};
      end
      default: ;
    endcase
  end

  assign cmd_rd_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      diff_q <= cmd_i.diff;
      raw_q  <= cmd_i.raw;
      keep_q <= cmd_i.keep;
    end else if (advance) begin
      diff_q <= diff_q >> 1;
      raw_q  <= raw_q >> 1;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        row_q <= '0;
        col_q <= '0;
      end else if (advance) begin
        if (col_q == COL_LAST) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- design/key_matrix_debounce_reporter_core.sv -----
// Key matrix debounce reporter: top level.
// Input queue side: push a scan (raw_keys_i, first_scan_i, now_us_i) while
// full is low. The front end updates the debounce timer and stable matrix
// in the accept cycle and queues a command in a two-entry command queue,
// so full only rises while two scans wait behind the back end.
// Result queue side: words appear while empty is low and leave on pop.
// A committing scan yields one key event per changed key, row by row and
// column by column, then a status word with last set; others yield only
// the status word.
// With nothing changed, a command passes from the command queue through the
// idle, scan and status states into the output word. The back end walks
// the diff one key per cycle up to the highest changed key while the
// result word is taken.
// A stalled receiver holds the output word; the back end waits on it and
// the command queue fills, after which full holds off new scans.
// Reset clears the stable matrix, timer and queues and loads a debounce
// time of 5000 us. cfg_we_i writes the debounce time; write it only idle.
`default_nettype none

module key_matrix_debounce_reporter_core (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [kmd_pkg::DBT_W-1:0]   cfg_wdata_i,
  input  wire                         push,
  output logic                        full,
  input  wire  [kmd_pkg::RAW_W-1:0]   raw_keys_i,
  input  wire                         first_scan_i,
  input  wire  [kmd_pkg::TIME_W-1:0]  now_us_i,
  output logic                        empty,
  input  wire                         pop,
  output logic                        kind_o,
  output logic [kmd_pkg::ROW_W-1:0]   key_row_o,
  output logic [kmd_pkg::COL_W-1:0]   key_col_o,
  output logic                        key_pressed_o,
  output logic                        keep_scanning_o,
  output logic                        last_o
);
  import kmd_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  res_t res;
  logic cq_full, cq_empty, cq_rd;
  logic accept;
  logic out_valid;
  logic out_pop;

  assign accept  = push && !cq_full;
  assign full    = cq_full;
  assign empty   = !out_valid;
  assign out_pop = pop && out_valid;

  kmd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .raw_keys_i   (raw_keys_i),
    .first_scan_i (first_scan_i),
    .now_us_i     (now_us_i),
    .cmd_o        (front_cmd)
  );

  kmd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_cmd),
    .full_o  (cq_full),
    .rd_i    (cq_rd),
    .rdata_o (back_cmd),
    .empty_o (cq_empty)
  );

  kmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cq_empty),
    .cmd_rd_o    (cq_rd),
    .pop_i       (out_pop),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign key_row_o       = res.row;
  assign key_col_o       = res.col;
  assign key_pressed_o   = res.pressed;
  assign keep_scanning_o = res.keep;
  assign last_o          = res.last;

  // the status word is always the last word of a scan
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == kind_o))
    else $error("last flag and word kind disagree");

  // key events only name keys inside the matrix
  a_event_in_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_EVENT)) |->
      ((key_row_o < ROW_W'(ROWS)) && (key_col_o < COL_W'(COLS)) && !keep_scanning_o))
    else $error("key event outside matrix");

  // the back end never takes a command from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_rd |-> !cq_empty)
    else $error("command queue read while empty");

  // a stalled output word holds its value
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res)))
    else $error("output word changed while stalled");

endmodule

`default_nettype wire
